### src/sqvg_pkg.sv
// Shared types and codes for the sprite quad vertex generator.
// No dependencies; imported by the controller, datapath, top unit and testbench.
package sqvg_pkg;

  localparam logic [1:0] KIND_SPRITE   = 2'd0;
  localparam logic [1:0] KIND_SHAPE    = 2'd1;
  localparam logic [1:0] KIND_TRIANGLE = 2'd2;

  localparam logic [1:0] REG_VIEW_LEFT   = 2'd0;
  localparam logic [1:0] REG_VIEW_RIGHT  = 2'd1;
  localparam logic [1:0] REG_VIEW_TOP    = 2'd2;
  localparam logic [1:0] REG_VIEW_BOTTOM = 2'd3;

  // datapath step codes issued by the controller
  localparam logic [3:0] STEP_NONE = 4'd0;
  localparam logic [3:0] STEP_TAB0 = 4'd1;
  localparam logic [3:0] STEP_TAB1 = 4'd2;
  localparam logic [3:0] STEP_M1   = 4'd3;
  localparam logic [3:0] STEP_M2   = 4'd4;
  localparam logic [3:0] STEP_M3   = 4'd5;
  localparam logic [3:0] STEP_M4   = 4'd6;
  localparam logic [3:0] STEP_M5   = 4'd7;
  localparam logic [3:0] STEP_M6   = 4'd8;
  localparam logic [3:0] STEP_M7   = 4'd9;
  localparam logic [3:0] STEP_M8   = 4'd10;
  localparam logic [3:0] STEP_M9   = 4'd11;
  localparam logic [3:0] STEP_DIV  = 4'd12;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [1:0]         primitive_kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        size_pair;
    logic [31:0]        scale_pair;
    logic [31:0]        pivot_pair;
    logic [15:0]        angle;
    logic [31:0]        u_pair;
    logic [31:0]        v_pair;
    logic [1:0]         flip_bits;
    logic [31:0]        color_rgba;
    logic               frame_start;
  } cmd_word_t;

  typedef struct packed {
    logic signed [15:0] clip_x;
    logic signed [15:0] clip_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [15:0]        vertex_address;
    logic               overflow;
    logic               last_vertex;
  } vertex_word_t;

  typedef struct packed {
    logic       load;
    logic [3:0] step;
    logic [2:0] vtx;
    logic       last;
    logic       push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic triangle;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

### src/sqvg_if.sv
// Valid/ready channel interfaces for command words and vertex words.
// Depends on nothing.
interface sqvg_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         primitive_kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        size_pair;
  logic [31:0]        scale_pair;
  logic [31:0]        pivot_pair;
  logic [15:0]        angle;
  logic [31:0]        u_pair;
  logic [31:0]        v_pair;
  logic [1:0]         flip_bits;
  logic [31:0]        color_rgba;
  logic               frame_start;

  modport source (output valid, primitive_kind, pos_x, pos_y, size_pair, scale_pair,
                  pivot_pair, angle, u_pair, v_pair, flip_bits, color_rgba, frame_start,
                  input ready);
  modport sink (input valid, primitive_kind, pos_x, pos_y, size_pair, scale_pair,
                pivot_pair, angle, u_pair, v_pair, flip_bits, color_rgba, frame_start,
                output ready);
endinterface

interface sqvg_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] clip_x;
  logic signed [15:0] clip_y;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [31:0]        vertex_color;
  logic [15:0]        vertex_address;
  logic               overflow;
  logic               last_vertex;

  modport source (output valid, clip_x, clip_y, tex_u, tex_v, vertex_color,
                  vertex_address, overflow, last_vertex, input ready);
  modport sink (input valid, clip_x, clip_y, tex_u, tex_v, vertex_color,
                vertex_address, overflow, last_vertex, output ready);
endinterface

### src/sqvg_ratio_div.sv
// Rounded ratio num*32768/den, clamped to +-2^17, restoring divider, 17 steps.
// Depends on nothing.
module sqvg_ratio_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [44:0] num,
  input  logic signed [32:0] den,
  output logic               busy,
  output logic signed [18:0] ratio
);

  localparam int QB = 17;
  localparam int CW = $clog2(QB + 1);

  logic [44:0]   abs_n;
  logic [32:0]   abs_d;
  logic [61:0]   n_full;
  logic [33:0]   d_full;
  logic          sat_now;
  logic [CW-1:0] cnt;
  logic [33:0]   rem;
  logic [33:0]   dreg;
  logic [QB-1:0] nlow;
  logic [QB-1:0] q;
  logic          neg;
  logic          sat;
  logic          zero;
  logic [34:0]   trial;
  logic [17:0]   mag;

  always_comb begin
    abs_n   = num[44] ? 45'(-num) : 45'(num);
    abs_d   = den[32] ? 33'(-den) : 33'(den);
    // 2*|n|*32768 + |d| over 2*|d| gives round half away from zero
    n_full  = {abs_n, 16'b0} + 62'(abs_d);
    d_full  = {abs_d, 1'b0};
    sat_now = n_full >= 62'({d_full, 17'b0});
    trial   = {rem, nlow[QB-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QB);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= n_full[50:17];
      nlow <= n_full[QB-1:0];
      dreg <= d_full;
      q    <= '0;
      neg  <= num[44] ^ den[32];
      sat  <= sat_now;
      zero <= den == '0;
    end else if (cnt != '0) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= 34'(trial - {1'b0, dreg});
        q   <= {q[QB-2:0], 1'b1};
      end else begin
        rem <= trial[33:0];
        q   <= {q[QB-2:0], 1'b0};
      end
      nlow <= {nlow[QB-2:0], 1'b0};
    end
  end

  always_comb begin
    if (zero)     mag = 18'd16384;
    else if (sat) mag = 18'd131072;
    else          mag = {1'b0, q};
    ratio = (neg && !zero) ? 19'(-{1'b0, mag}) : {1'b0, mag};
  end

  assign busy = cnt != '0;

endmodule

### src/sqvg_ctrl.sv
// Sequencer for the vertex datapath: table setup, multiply steps, divide, push.
// Depends on sqvg_pkg.
module sqvg_ctrl
  import sqvg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output ctrl_cmd_t  cmd,
  input  dp_status_t status
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TAB0 = 4'd1;
  localparam logic [3:0] S_TAB1 = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_M4   = 4'd6;
  localparam logic [3:0] S_M5   = 4'd7;
  localparam logic [3:0] S_M6   = 4'd8;
  localparam logic [3:0] S_M7   = 4'd9;
  localparam logic [3:0] S_M8   = 4'd10;
  localparam logic [3:0] S_M9   = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_WAIT = 4'd13;
  localparam logic [3:0] S_PUSH = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] vtx;
  logic [2:0] vtx_next;
  logic       last;

  assign last = vtx == (status.triangle ? 3'd2 : 3'd5);

  always_comb begin
    state_next = state;
    vtx_next   = vtx;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.vtx    = vtx;
    cmd.last   = last;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        vtx_next = 3'd0;
        if (in_valid) state_next = S_TAB0;
      end
      S_TAB0: begin cmd.step = STEP_TAB0; state_next = S_TAB1; end
      S_TAB1: begin cmd.step = STEP_TAB1; state_next = S_M1; end
      S_M1:   begin cmd.step = STEP_M1; state_next = S_M2; end
      S_M2:   begin cmd.step = STEP_M2; state_next = S_M3; end
      S_M3:   begin cmd.step = STEP_M3; state_next = S_M4; end
      S_M4:   begin cmd.step = STEP_M4; state_next = S_M5; end
      S_M5:   begin cmd.step = STEP_M5; state_next = S_M6; end
      S_M6:   begin cmd.step = STEP_M6; state_next = S_M7; end
      S_M7:   begin cmd.step = STEP_M7; state_next = S_M8; end
      S_M8:   begin cmd.step = STEP_M8; state_next = S_M9; end
      S_M9:   begin cmd.step = STEP_M9; state_next = S_DIV; end
      S_DIV:  begin cmd.step = STEP_DIV; state_next = S_WAIT; end
      S_WAIT: begin
        if (!status.div_busy) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push = 1'b1;
          if (last) begin
            state_next = S_IDLE;
          end else begin
            vtx_next   = vtx + 3'd1;
            state_next = S_M1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vtx   <= 3'd0;
    end else begin
      state <= state_next;
      vtx   <= vtx_next;
    end
  end

endmodule

### src/sqvg_datapath.sv
// Vertex datapath: view registers, sine table, shared multiplier, two ratio
// dividers, address counter and output register. Depends on sqvg_pkg, sqvg_ratio_div.
module sqvg_datapath
  import sqvg_pkg::*;
#(
  parameter int VERTEX_BUFFER_DEPTH = 65536,
  parameter int SINE_TABLE_DEPTH    = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  cmd_word_t    cmd_word,
  input  ctrl_cmd_t    cmd,
  output dp_status_t   status,
  output logic         out_valid,
  input  logic         out_ready,
  output vertex_word_t out_word
);

  localparam int AW  = $clog2(VERTEX_BUFFER_DEPTH);
  localparam int NVW = $clog2(VERTEX_BUFFER_DEPTH + 1);
  localparam int FW  = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int TW  = $clog2(SINE_TABLE_DEPTH + 1);

  function automatic logic [15:0] quarter_sine(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    return (sum > 64'sd32768) ? 16'd32768 : sum[15:0];
  endfunction

  // {negate, table index} for a full-circle index
  function automatic logic [TW:0] wave_lookup(input logic [FW-1:0] f);
    logic [1:0]    qd;
    logic [FW-1:0] base;
    logic [FW-1:0] r;
    if (f >= FW'(3 * SINE_TABLE_DEPTH)) begin
      qd = 2'd3; base = FW'(3 * SINE_TABLE_DEPTH);
    end else if (f >= FW'(2 * SINE_TABLE_DEPTH)) begin
      qd = 2'd2; base = FW'(2 * SINE_TABLE_DEPTH);
    end else if (f >= FW'(SINE_TABLE_DEPTH)) begin
      qd = 2'd1; base = FW'(SINE_TABLE_DEPTH);
    end else begin
      qd = 2'd0; base = '0;
    end
    r = f - base;
    return {qd[1], qd[0] ? TW'(FW'(SINE_TABLE_DEPTH) - r) : TW'(r)};
  endfunction

  logic [15:0] sine_rom [0:SINE_TABLE_DEPTH];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] X = HALF_PI_Q30 * 64'(i) / SINE_TABLE_DEPTH;
    assign sine_rom[i] = quarter_sine(X);
  end

  // view registers
  logic signed [31:0] view_left, view_right, view_top, view_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_left   <= 32'sd0;
      view_right  <= 32'sd65536;
      view_top    <= 32'sd0;
      view_bottom <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIEW_LEFT:   view_left   <= cfg_data;
        REG_VIEW_RIGHT:  view_right  <= cfg_data;
        REG_VIEW_TOP:    view_top    <= cfg_data;
        REG_VIEW_BOTTOM: view_bottom <= cfg_data;
      endcase
    end
  end

  // command fields
  logic               is_tri;
  logic signed [31:0] px, py;
  logic [15:0]        w, h, pvx, pvy, u0, u1, v0, v1, ang;
  logic signed [15:0] sx, sy;
  logic [31:0]        color;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_tri <= cmd_word.primitive_kind == KIND_TRIANGLE;
      px     <= cmd_word.pos_x;
      py     <= cmd_word.pos_y;
      w      <= cmd_word.size_pair[31:16];
      h      <= cmd_word.size_pair[15:0];
      sx     <= cmd_word.scale_pair[31:16];
      sy     <= cmd_word.scale_pair[15:0];
      if (cmd_word.primitive_kind == KIND_SPRITE) begin
        pvx <= cmd_word.pivot_pair[31:16];
        pvy <= cmd_word.pivot_pair[15:0];
      end else begin
        pvx <= 16'd16384;
        pvy <= 16'd16384;
      end
      ang    <= cmd_word.angle;
      u0     <= cmd_word.flip_bits[0] ? cmd_word.u_pair[15:0]  : cmd_word.u_pair[31:16];
      u1     <= cmd_word.flip_bits[0] ? cmd_word.u_pair[31:16] : cmd_word.u_pair[15:0];
      v0     <= cmd_word.flip_bits[1] ? cmd_word.v_pair[15:0]  : cmd_word.v_pair[31:16];
      v1     <= cmd_word.flip_bits[1] ? cmd_word.v_pair[31:16] : cmd_word.v_pair[15:0];
      color  <= cmd_word.color_rgba;
    end
  end

  // sine and cosine for the command angle
  logic [31:0]        ang_prod;
  logic [FW-1:0]      full_s, full_c;
  logic [FW:0]        full_c_raw;
  logic [TW:0]        look_s, look_c;
  logic [TW-1:0]      sin_idx, cos_idx;
  logic               sin_neg, cos_neg;
  logic signed [16:0] sin_v, cos_v;

  always_comb begin
    ang_prod   = 32'(ang) * 32'(4 * SINE_TABLE_DEPTH);
    full_s     = FW'(ang_prod >> 16);
    full_c_raw = {1'b0, full_s} + (FW+1)'(SINE_TABLE_DEPTH);
    if (full_c_raw >= (FW+1)'(4 * SINE_TABLE_DEPTH))
      full_c = FW'(full_c_raw - (FW+1)'(4 * SINE_TABLE_DEPTH));
    else
      full_c = full_c_raw[FW-1:0];
    look_s = wave_lookup(full_s);
    look_c = wave_lookup(full_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.step == STEP_TAB0) begin
      sin_neg <= look_s[TW];
      sin_idx <= look_s[TW-1:0];
      cos_neg <= look_c[TW];
      cos_idx <= look_c[TW-1:0];
    end
    if (cmd.step == STEP_TAB1) begin
      sin_v <= sin_neg ? 17'(-{1'b0, sine_rom[sin_idx]}) : {1'b0, sine_rom[sin_idx]};
      cos_v <= cos_neg ? 17'(-{1'b0, sine_rom[cos_idx]}) : {1'b0, sine_rom[cos_idx]};
    end
  end

  // local offset of this vertex
  logic               cx1, cy1;
  logic signed [17:0] ox, oy;
  logic [15:0]        tu, tv;

  always_comb begin
    cx1 = cmd.vtx == 3'd1 || cmd.vtx == 3'd2 || cmd.vtx == 3'd4;
    cy1 = cmd.vtx == 3'd2 || cmd.vtx == 3'd4 || cmd.vtx == 3'd5;
    if (is_tri) begin
      unique case (cmd.vtx)
        3'd0:    begin ox = -18'sd16384; oy = 18'sd16384; end
        3'd1:    begin ox = 18'sd16384;  oy = 18'sd16384; end
        default: begin ox = 18'sd0;      oy = -18'sd16384; end
      endcase
      tu = 16'd16384;
      tv = 16'd16384;
    end else begin
      ox = (cx1 ? 18'sd32768 : 18'sd0) - $signed({2'b0, pvx});
      oy = (cy1 ? 18'sd32768 : 18'sd0) - $signed({2'b0, pvy});
      tu = cx1 ? u1 : u0;
      tv = cy1 ? v1 : v0;
    end
  end

  // shared multiplier
  logic signed [39:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [56:0] p, acc;
  logic signed [56:0] p_r11;
  logic signed [39:0] lx, ly;
  logic signed [57:0] rot_x, rot_y;
  logic signed [43:0] wx, wy;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      STEP_M1: begin mul_a = 40'(ox);       mul_b = $signed({1'b0, w}); end
      STEP_M2: begin mul_a = p[39:0];       mul_b = 17'(sx); end
      STEP_M3: begin mul_a = 40'(oy);       mul_b = $signed({1'b0, h}); end
      STEP_M4: begin mul_a = p[39:0];       mul_b = 17'(sy); end
      STEP_M5: begin mul_a = lx;            mul_b = cos_v; end
      STEP_M6: begin mul_a = ly;            mul_b = sin_v; end
      STEP_M7: begin mul_a = lx;            mul_b = sin_v; end
      STEP_M8: begin mul_a = ly;            mul_b = cos_v; end
      default: ;
    endcase
    p_r11 = p + 57'sd1024;
    rot_x = {acc[56], acc} - {p[56], p} + 58'sd16384;
    rot_y = {acc[56], acc} + {p[56], p} + 58'sd16384;
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      STEP_M1, STEP_M2, STEP_M4, STEP_M7: p <= mul_a * mul_b;
      STEP_M3: begin p <= mul_a * mul_b; lx <= p_r11[50:11]; end
      STEP_M5: begin p <= mul_a * mul_b; ly <= p_r11[50:11]; end
      STEP_M6: begin p <= mul_a * mul_b; acc <= p; end
      STEP_M8: begin p <= mul_a * mul_b; acc <= p; end
      default: ;
    endcase
    if (cmd.step == STEP_M7) wx <= 44'(rot_x >>> 15) + 44'(px);
    if (cmd.step == STEP_M9) wy <= 44'(rot_y >>> 15) + 44'(py);
  end

  // projection
  logic               div_start;
  logic signed [44:0] num_x, num_y;
  logic signed [32:0] den_x, den_y;
  logic               busy_x, busy_y;
  logic signed [18:0] ratio_x, ratio_y;

  assign div_start = cmd.step == STEP_DIV;
  assign num_x = 45'(wx) - 45'(view_left);
  assign num_y = 45'(wy) - 45'(view_top);
  assign den_x = 33'(view_right) - 33'(view_left);
  assign den_y = 33'(view_bottom) - 33'(view_top);

  sqvg_ratio_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_x),
    .den   (den_x),
    .busy  (busy_x),
    .ratio (ratio_x)
  );

  sqvg_ratio_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_y),
    .den   (den_y),
    .busy  (busy_y),
    .ratio (ratio_y)
  );

  logic signed [19:0] cx_pre, cy_pre;
  logic signed [15:0] cx, cy;

  always_comb begin
    cx_pre = 20'(ratio_x) - 20'sd16384;
    cy_pre = 20'sd16384 - 20'(ratio_y);
    if (cx_pre > 20'sd32767)       cx = 16'sd32767;
    else if (cx_pre < -20'sd32768) cx = -16'sd32768;
    else                           cx = cx_pre[15:0];
    if (cy_pre > 20'sd32767)       cy = 16'sd32767;
    else if (cy_pre < -20'sd32768) cy = -16'sd32768;
    else                           cy = cy_pre[15:0];
  end

  // vertex address and output word
  logic [NVW-1:0] nv;
  logic           full;

  assign full = nv >= NVW'(VERTEX_BUFFER_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= '0;
    end else if (cmd.load && cmd_word.frame_start) begin
      nv <= '0;
    end else if (cmd.push && !full) begin
      nv <= nv + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_word.clip_x         <= cx;
      out_word.clip_y         <= cy;
      out_word.tex_u          <= tu;
      out_word.tex_v          <= tv;
      out_word.vertex_color   <= color;
      out_word.vertex_address <= full ? 16'(AW'(VERTEX_BUFFER_DEPTH - 1)) : 16'(nv[AW-1:0]);
      out_word.overflow       <= full;
      out_word.last_vertex    <= cmd.last;
    end
  end

  assign status.triangle = is_tri;
  assign status.div_busy = busy_x || busy_y;
  assign status.out_free = !out_valid || out_ready;

endmodule

### src/sprite_quad_vertex_generator_unit.sv
// Sprite quad vertex generator: one draw command in, 3 or 6 vertex words out.
// Per vertex: 9 steps on the shared 40x17 multiplier, the divider start, a wait until the
// 17-step restoring dividers finish, then the push, which waits while the output is stalled;
// per command also the accept and the table setup steps.
// Synchronous active-high reset: view 0..1 on both axes, vertex address 0.
module sprite_quad_vertex_generator_unit
  import sqvg_pkg::*;
#(
  parameter int VERTEX_BUFFER_DEPTH = 65536,
  parameter int SINE_TABLE_DEPTH    = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  sqvg_cmd_if.sink    cmd,
  sqvg_vtx_if.source  vtx
);

  cmd_word_t    cmd_word;
  vertex_word_t out_word;
  ctrl_cmd_t    ctl;
  dp_status_t   status;
  logic         in_ready;
  logic         out_valid;

  assign cmd_word.primitive_kind = cmd.primitive_kind;
  assign cmd_word.pos_x          = cmd.pos_x;
  assign cmd_word.pos_y          = cmd.pos_y;
  assign cmd_word.size_pair      = cmd.size_pair;
  assign cmd_word.scale_pair     = cmd.scale_pair;
  assign cmd_word.pivot_pair     = cmd.pivot_pair;
  assign cmd_word.angle          = cmd.angle;
  assign cmd_word.u_pair         = cmd.u_pair;
  assign cmd_word.v_pair         = cmd.v_pair;
  assign cmd_word.flip_bits      = cmd.flip_bits;
  assign cmd_word.color_rgba     = cmd.color_rgba;
  assign cmd_word.frame_start    = cmd.frame_start;
  assign cmd.ready               = in_ready;

  sqvg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .cmd      (ctl),
    .status   (status)
  );

  sqvg_datapath #(
    .VERTEX_BUFFER_DEPTH (VERTEX_BUFFER_DEPTH),
    .SINE_TABLE_DEPTH    (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_word  (cmd_word),
    .cmd       (ctl),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (vtx.ready),
    .out_word  (out_word)
  );

  assign vtx.valid          = out_valid;
  assign vtx.clip_x         = out_word.clip_x;
  assign vtx.clip_y         = out_word.clip_y;
  assign vtx.tex_u          = out_word.tex_u;
  assign vtx.tex_v          = out_word.tex_v;
  assign vtx.vertex_color   = out_word.vertex_color;
  assign vtx.vertex_address = out_word.vertex_address;
  assign vtx.overflow       = out_word.overflow;
  assign vtx.last_vertex    = out_word.last_vertex;

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for sprite_quad_vertex_generator_unit: random and directed draw
// commands with a bit-exact vertex predictor in a scoreboard class.
// Depends on sqvg_pkg, the sqvg_cmd_if / sqvg_vtx_if interfaces and the unit under test.
module tb_top;
  import sqvg_pkg::*;

  localparam int BUF_DEPTH   = 65536;
  localparam int SIN_DEPTH   = 1024;
  localparam int CYCLE_LIMIT = 20000000;

  class vertex_scoreboard;
    vertex_word_t pending_vtx[$];
    longint       view_l, view_r, view_t, view_b;
    int unsigned  next_vtx;
    int           errors;
    longint       qsin[SIN_DEPTH+1];

    function new();
      for (int i = 0; i <= SIN_DEPTH; i++) qsin[i] = quarter(i);
      view_l = 0; view_r = 65536; view_t = 0; view_b = 65536;
      next_vtx = 0;
      errors = 0;
    endfunction

    function longint quarter(int i);
      longint unsigned x, x2, term;
      longint sum;
      x = HALF_PI_Q30 * longint'(i) / SIN_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k & 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      return (sum > 32768) ? 32768 : sum;
    endfunction

    function longint sine_at(int unsigned idx);
      int unsigned q, r;
      longint m;
      q = (idx / SIN_DEPTH) & 3;
      r = idx % SIN_DEPTH;
      m = (q & 1) ? qsin[SIN_DEPTH - r] : qsin[r];
      return (q & 2) ? -m : m;
    endfunction

    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint ratio_q15(longint num, longint den);
      bit neg;
      longint un, ud;
      if (den == 0) return 16384;
      num = num * 32768;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      un = (2 * un + ud) / (2 * ud);
      return neg ? -un : un;
    endfunction

    function longint sat16(longint v);
      return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function void set_view(logic [1:0] idx, logic [31:0] data);
      longint v;
      v = longint'($signed(data));
      case (idx)
        REG_VIEW_LEFT:   view_l = v;
        REG_VIEW_RIGHT:  view_r = v;
        REG_VIEW_TOP:    view_t = v;
        REG_VIEW_BOTTOM: view_b = v;
        default: ;
      endcase
    endfunction

    // accepted command: push its expected vertex words
    function void note_cmd(cmd_word_t c);
      longint px, py, w, h, sx, sy, pvx, pvy, s, co;
      longint ox, oy, lx, ly, wx, wy;
      logic [15:0] ua, ub, va, vb, u0, u1, v0, v1;
      int unsigned full;
      int cnt;
      bit cx1, cy1;
      vertex_word_t e;
      px = longint'(c.pos_x);
      py = longint'(c.pos_y);
      w = longint'(c.size_pair[31:16]);
      h = longint'(c.size_pair[15:0]);
      sx = longint'($signed(c.scale_pair[31:16]));
      sy = longint'($signed(c.scale_pair[15:0]));
      pvx = longint'(c.pivot_pair[31:16]);
      pvy = longint'(c.pivot_pair[15:0]);
      ua = c.u_pair[31:16]; ub = c.u_pair[15:0];
      va = c.v_pair[31:16]; vb = c.v_pair[15:0];
      u0 = c.flip_bits[0] ? ub : ua; u1 = c.flip_bits[0] ? ua : ub;
      v0 = c.flip_bits[1] ? vb : va; v1 = c.flip_bits[1] ? va : vb;
      full = (int'(c.angle) * 4 * SIN_DEPTH) >> 16;
      s = sine_at(full);
      co = sine_at((full + SIN_DEPTH) % (4 * SIN_DEPTH));
      cnt = (c.primitive_kind == KIND_TRIANGLE) ? 3 : 6;
      if (c.frame_start) next_vtx = 0;
      if (c.primitive_kind != KIND_SPRITE) begin
        pvx = 16384; pvy = 16384;
      end
      for (int k = 0; k < cnt; k++) begin
        if (c.primitive_kind == KIND_TRIANGLE) begin
          ox = (k == 0) ? -16384 : ((k == 1) ? 16384 : 0);
          oy = (k == 2) ? -16384 : 16384;
          e.tex_u = 16'd16384;
          e.tex_v = 16'd16384;
        end else begin
          // quad corners (0,0)(1,0)(1,1)(0,0)(1,1)(0,1)
          cx1 = (k == 1) || (k == 2) || (k == 4);
          cy1 = (k == 2) || (k == 4) || (k == 5);
          ox = (cx1 ? 32768 : 0) - pvx;
          oy = (cy1 ? 32768 : 0) - pvy;
          e.tex_u = cx1 ? u1 : u0;
          e.tex_v = cy1 ? v1 : v0;
        end
        lx = rnd_shift(ox * w * sx, 11);
        ly = rnd_shift(oy * h * sy, 11);
        wx = px + rnd_shift(lx * co - ly * s, 15);
        wy = py + rnd_shift(lx * s + ly * co, 15);
        e.clip_x = 16'(sat16(ratio_q15(wx - view_l, view_r - view_l) - 16384));
        e.clip_y = 16'(sat16(16384 - ratio_q15(wy - view_t, view_b - view_t)));
        e.vertex_color = c.color_rgba;
        if (next_vtx < BUF_DEPTH) begin
          e.vertex_address = 16'(next_vtx);
          e.overflow = 1'b0;
          next_vtx++;
        end else begin
          e.vertex_address = 16'(BUF_DEPTH - 1);
          e.overflow = 1'b1;
        end
        e.last_vertex = (k == cnt - 1);
        pending_vtx.push_back(e);
      end
    endfunction

    function void report(string fld, longint ex, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, ex, got);
    endfunction

    function void check_vtx(vertex_word_t got);
      vertex_word_t ex;
      if (pending_vtx.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex word, expected none, actual %p", $time, got);
        return;
      end
      ex = pending_vtx.pop_front();
      if (got.clip_x !== ex.clip_x) report("clip_x", ex.clip_x, got.clip_x);
      if (got.clip_y !== ex.clip_y) report("clip_y", ex.clip_y, got.clip_y);
      if (got.tex_u !== ex.tex_u) report("tex_u", ex.tex_u, got.tex_u);
      if (got.tex_v !== ex.tex_v) report("tex_v", ex.tex_v, got.tex_v);
      if (got.vertex_color !== ex.vertex_color)
        report("vertex_color", ex.vertex_color, got.vertex_color);
      if (got.vertex_address !== ex.vertex_address)
        report("vertex_address", ex.vertex_address, got.vertex_address);
      if (got.overflow !== ex.overflow) report("overflow", ex.overflow, got.overflow);
      if (got.last_vertex !== ex.last_vertex)
        report("last_vertex", ex.last_vertex, got.last_vertex);
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          tx_pct, rx_pct;
  int          cycles;

  sqvg_cmd_if cmd_ch();
  sqvg_vtx_if vtx_ch();

  vertex_scoreboard sb = new();

  sprite_quad_vertex_generator_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd_ch), .vtx(vtx_ch)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sprite_quad_vertex_generator_unit test failed");
      $finish;
    end
  end

  always @(negedge clk) vtx_ch.ready <= ($urandom_range(99) >= rx_pct);

  always @(posedge clk) begin
    vertex_word_t got;
    if (!rst && vtx_ch.valid && vtx_ch.ready) begin
      got.clip_x = vtx_ch.clip_x;
      got.clip_y = vtx_ch.clip_y;
      got.tex_u = vtx_ch.tex_u;
      got.tex_v = vtx_ch.tex_v;
      got.vertex_color = vtx_ch.vertex_color;
      got.vertex_address = vtx_ch.vertex_address;
      got.overflow = vtx_ch.overflow;
      got.last_vertex = vtx_ch.last_vertex;
      sb.check_vtx(got);
    end
  end

  task automatic write_view(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_view(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_views(logic [31:0] l, logic [31:0] r, logic [31:0] t, logic [31:0] b);
    wait (sb.pending_vtx.size() == 0);
    repeat (64) @(negedge clk);
    write_view(REG_VIEW_LEFT, l);
    write_view(REG_VIEW_RIGHT, r);
    write_view(REG_VIEW_TOP, t);
    write_view(REG_VIEW_BOTTOM, b);
  endtask

  // called at a falling edge; leaves the caller at a falling edge with valid low
  task automatic send_cmd(cmd_word_t c);
    while ($urandom_range(99) < tx_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.primitive_kind = c.primitive_kind;
    cmd_ch.pos_x = c.pos_x;
    cmd_ch.pos_y = c.pos_y;
    cmd_ch.size_pair = c.size_pair;
    cmd_ch.scale_pair = c.scale_pair;
    cmd_ch.pivot_pair = c.pivot_pair;
    cmd_ch.angle = c.angle;
    cmd_ch.u_pair = c.u_pair;
    cmd_ch.v_pair = c.v_pair;
    cmd_ch.flip_bits = c.flip_bits;
    cmd_ch.color_rgba = c.color_rgba;
    cmd_ch.frame_start = c.frame_start;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_cmd(c);
    @(negedge clk);
    cmd_ch.valid = 1'b0;
  endtask

  function automatic longint pick_in(longint lo, longint hi);
    return lo + (hi - lo) * longint'($urandom_range(1000)) / 1000;
  endfunction

  // mostly positions inside the current view and moderate sizes; some raw noise
  function automatic cmd_word_t rand_cmd();
    cmd_word_t c;
    logic [351:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
    c = noise[$bits(cmd_word_t)-1:0];
    c.primitive_kind = 2'($urandom_range(3));
    c.frame_start = ($urandom_range(9) == 0);
    if ($urandom_range(4) != 0) begin
      c.pos_x = 32'(pick_in(sb.view_l, sb.view_r));
      c.pos_y = 32'(pick_in(sb.view_t, sb.view_b));
      c.size_pair[31:16] = 16'($urandom) >> $urandom_range(15);
      c.size_pair[15:0] = 16'($urandom) >> $urandom_range(15);
      c.scale_pair[31:16] = 16'(256 + $signed(10'($urandom)));
      c.scale_pair[15:0] = 16'(256 + $signed(10'($urandom)));
      c.pivot_pair = {16'($urandom_range(32768)), 16'($urandom_range(32768))};
    end
    return c;
  endfunction

  task automatic random_phase(int n, int tp, int rp);
    tx_pct = tp;
    rx_pct = rp;
    repeat (n) send_cmd(rand_cmd());
    tx_pct = 0;
    rx_pct = 0;
  endtask

  initial begin
    cmd_word_t c;
    logic [15:0] ang[5] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    rst = 1'b1;
    cycles = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_pct = 0;
    rx_pct = 0;
    vtx_ch.ready = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.primitive_kind = '0;
    cmd_ch.pos_x = '0;
    cmd_ch.pos_y = '0;
    cmd_ch.size_pair = '0;
    cmd_ch.scale_pair = '0;
    cmd_ch.pivot_pair = '0;
    cmd_ch.angle = '0;
    cmd_ch.u_pair = '0;
    cmd_ch.v_pair = '0;
    cmd_ch.flip_bits = '0;
    cmd_ch.color_rgba = '0;
    cmd_ch.frame_start = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: every kind incl. the undefined one, extreme fields, flips, angles
    for (int i = 0; i < 20; i++) begin
      c.primitive_kind = 2'(i % 4);
      c.pos_x = (i % 5 == 0) ? 32'sh8000_0000 : ((i % 5 == 1) ? 32'sh7FFF_FFFF : 32'sh8000);
      c.pos_y = (i % 3 == 0) ? 32'sh7FFF_FFFF : ((i % 3 == 1) ? 32'sh8000_0000 : 32'sh4000);
      c.size_pair = (i < 4) ? 32'h0010_0010 : ((i < 8) ? 32'hFFFF_FFFF : 32'h0000_0008);
      c.scale_pair = (i % 4 == 1) ? 32'h8000_7FFF : ((i % 4 == 2) ? 32'h7FFF_8000 :
                     ((i == 12) ? 32'h0 : 32'h0100_0100));
      c.pivot_pair = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
      c.angle = ang[i % 5];
      c.u_pair = (i % 3 == 0) ? 32'hFFFF_0000 : 32'h0000_8000;
      c.v_pair = (i % 3 == 1) ? 32'h0000_FFFF : 32'h8000_1234;
      c.flip_bits = 2'(i % 4);
      c.color_rgba = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
      c.frame_start = (i == 10);
      send_cmd(c);
    end

    set_views(32'hFFC0_0000, 32'h0040_0000, 32'hFFDC_0000, 32'h0024_0000);
    random_phase(60, 0, 0);
    // mirrored view on both axes
    set_views(32'h0064_0000, 32'hFF9C_0000, 32'h0010_0000, 32'hFFF0_0000);
    random_phase(50, 46, 0);
    // zero span on x, widest span on y
    set_views(32'h0003_0000, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    random_phase(50, 0, 46);
    set_views(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    random_phase(50, 20, 20);
    set_views(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000);
    random_phase(50, 46, 46);

    // a few more under stalls, then clear the vertex address with a frame start
    tx_pct = 20;
    rx_pct = 20;
    repeat (4) begin
      c = rand_cmd();
      c.frame_start = 1'b0;
      send_cmd(c);
    end
    c = rand_cmd();
    c.frame_start = 1'b1;
    send_cmd(c);
    cmd_ch.valid = 1'b0;

    wait (sb.pending_vtx.size() == 0);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_vtx.size() == 0)
      $display("sprite_quad_vertex_generator_unit test passed");
    else
      $display("sprite_quad_vertex_generator_unit test failed");
    $finish;
  end
endmodule
